[rtl/core/scss_pkg.sv]
// ============================================================================
// scss_pkg
// Shared types and constants for the strong component spanning stats block.
// ============================================================================
package scss_pkg;

    // Default capacities
    localparam int MAX_NODES_DEF = 256;
    localparam int MAX_EDGES_DEF = 1024;

    // Fixed field widths
    localparam int NODE_FW = 9;
    localparam int LEN_W   = 16;
    localparam int ANS_W   = 24;
    localparam int IDX_W   = 2;
    localparam int QCNT_W  = 3;
    localparam int CFG_W   = 9;

    localparam logic [ANS_W-1:0] WMAX = {ANS_W{1'b1}};

    // Input modes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ANALYZE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_NODE_COUNT     = 1'b0;
    localparam logic CFG_QUESTION_COUNT = 1'b1;

    // Answer codes
    localparam logic [IDX_W-1:0] ANS_COUNT      = 2'd0;
    localparam logic [IDX_W-1:0] ANS_MAX_SIZE   = 2'd1;
    localparam logic [IDX_W-1:0] ANS_MAX_WEIGHT = 2'd2;
    localparam logic [IDX_W-1:0] ANS_TOTAL      = 2'd3;

    // Commands from the input side to the sequencer
    typedef struct packed {
        logic load;
        logic analyze;
    } scss_cmd_t;

    // Result offered by the sequencer
    typedef struct packed {
        logic             valid;
        logic [ANS_W-1:0] answer;
        logic [IDX_W-1:0] index;
        logic             last;
    } scss_res_t;

endpackage

[rtl/core/scss_alu.sv]
// ============================================================================
// scss_alu
// Shared compare and saturating add unit used by the sequencer.
// ============================================================================
module scss_alu
    import scss_pkg::*;
(
    input  logic [ANS_W-1:0] a,
    input  logic [ANS_W-1:0] b,
    output logic             lt,
    output logic             eq,
    output logic [ANS_W-1:0] sum
);

    logic [ANS_W:0] wide_sum;

    // Compare operands
    assign lt = (a < b);
    assign eq = (a == b);

    // Add and clamp at the top of the range
    assign wide_sum = {1'b0, a} + {1'b0, b};
    assign sum      = wide_sum[ANS_W] ? WMAX : wide_sum[ANS_W-1:0];

endmodule

[rtl/core/scss_seq.sv]
// ============================================================================
// scss_seq
// Sequencer with edge table and working stores: iterative component search,
// candidate marking, minimum edge selection with union-find, answer collection.
// ============================================================================
module scss_seq
    import scss_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  scss_cmd_t                    cmd,
    input  logic [NODE_FW-1:0]           from_node,
    input  logic [NODE_FW-1:0]           to_node,
    input  logic [LEN_W-1:0]             cost,
    input  logic [$clog2(MAX_NODES):0]   nc,
    input  logic [QCNT_W-1:0]            q,
    input  logic                         res_take,
    output scss_res_t                    res,
    output logic                         busy
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = NW + 1;
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int ECW = EW + 1;
    localparam int KW  = LEN_W + EW;

    localparam logic [NCW-1:0] UNSEEN = {NCW{1'b1}};
    localparam logic [NW-1:0]  LAST_NODE = NW'(MAX_NODES - 1);
    localparam logic [ECW-1:0] EDGE_CAP  = ECW'(MAX_EDGES);

    // Sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLR    = 5'd1;
    localparam logic [4:0] S_ROOT   = 5'd2;
    localparam logic [4:0] S_ROOT_W = 5'd3;
    localparam logic [4:0] S_VISIT  = 5'd4;
    localparam logic [4:0] S_TOP    = 5'd5;
    localparam logic [4:0] S_TOP_W  = 5'd6;
    localparam logic [4:0] S_SCAN   = 5'd7;
    localparam logic [4:0] S_SCAN_W = 5'd8;
    localparam logic [4:0] S_EDGE_W = 5'd9;
    localparam logic [4:0] S_POP    = 5'd10;
    localparam logic [4:0] S_POP_W1 = 5'd11;
    localparam logic [4:0] S_POP_W2 = 5'd12;
    localparam logic [4:0] S_POP_W3 = 5'd13;
    localparam logic [4:0] S_POPC   = 5'd14;
    localparam logic [4:0] S_POPC_W = 5'd15;
    localparam logic [4:0] S_CND    = 5'd16;
    localparam logic [4:0] S_CND_W1 = 5'd17;
    localparam logic [4:0] S_CND_W2 = 5'd18;
    localparam logic [4:0] S_CND_W3 = 5'd19;
    localparam logic [4:0] S_SEL    = 5'd20;
    localparam logic [4:0] S_SEL_E  = 5'd21;
    localparam logic [4:0] S_FA0    = 5'd22;
    localparam logic [4:0] S_FA     = 5'd23;
    localparam logic [4:0] S_FA_W   = 5'd24;
    localparam logic [4:0] S_FB     = 5'd25;
    localparam logic [4:0] S_FB_W   = 5'd26;
    localparam logic [4:0] S_ADDW   = 5'd27;
    localparam logic [4:0] S_ANS    = 5'd28;
    localparam logic [4:0] S_ANS_W  = 5'd29;
    localparam logic [4:0] S_EMIT   = 5'd30;

    // Edge table
    logic [NW-1:0]    esrc_mem [MAX_EDGES];
    logic [NW-1:0]    edst_mem [MAX_EDGES];
    logic [LEN_W-1:0] elen_mem [MAX_EDGES];
    logic             ecand_mem[MAX_EDGES];
    logic [NW-1:0]    ecomp_mem[MAX_EDGES];

    // Node stores
    logic [NCW-1:0]   disc_mem [MAX_NODES];
    logic [NCW-1:0]   low_mem  [MAX_NODES];
    logic             onstk_mem[MAX_NODES];
    logic [NW-1:0]    ns_mem   [MAX_NODES];
    logic [NW-1:0]    wn_mem   [MAX_NODES];
    logic [ECW-1:0]   wp_mem   [MAX_NODES];
    logic [NW-1:0]    cof_mem  [MAX_NODES];
    logic [NCW-1:0]   csize_mem[MAX_NODES];
    logic [ANS_W-1:0] cw_mem   [MAX_NODES];
    logic [NW-1:0]    par_mem  [MAX_NODES];

    // Memory ports
    logic             edge_we;
    logic [EW-1:0]    edge_wa, edge_ra;
    logic [NW-1:0]    esrc_wd, edst_wd, esrc_rd, edst_rd;
    logic [LEN_W-1:0] elen_rd;
    logic [EW-1:0]    elen_ra;
    logic             ecand_we, ecand_wd, ecand_rd;
    logic             ecomp_we;
    logic [EW-1:0]    ecomp_ra;
    logic [NW-1:0]    ecomp_rd;

    logic             disc_we, low_we, onstk_we, ns_we, wn_we, wp_we;
    logic             cof_we, csize_we, cw_we, par_we;
    logic [NW-1:0]    disc_wa, low_wa, onstk_wa, ns_wa, wn_wa, wp_wa;
    logic [NW-1:0]    cof_wa, csize_wa, cw_wa, par_wa;
    logic [NW-1:0]    disc_ra, low_ra, onstk_ra, ns_ra, wn_ra, wp_ra;
    logic [NW-1:0]    cofa_ra, cofb_ra, csize_ra, cw_ra, par_ra;
    logic [NCW-1:0]   disc_wd, low_wd, csize_wd;
    logic             onstk_wd;
    logic [NW-1:0]    ns_wd, wn_wd, cof_wd, par_wd;
    logic [ECW-1:0]   wp_wd;
    logic [ANS_W-1:0] cw_wd;
    logic [NCW-1:0]   disc_rd, low_rd, csize_rd;
    logic             onstk_rd;
    logic [NW-1:0]    ns_rd, wn_rd, cofa_rd, cofb_rd, par_rd;
    logic [ECW-1:0]   wp_rd;
    logic [ANS_W-1:0] cw_rd;

    // Control and working registers
    logic [4:0]       state_reg, state_next;
    logic [ECW-1:0]   edges_reg;
    logic [NW-1:0]    clr_reg;
    logic [NCW-1:0]   r_reg, vc_reg, sp_reg, cp_reg, ncomp_reg, size_reg;
    logic [NCW-1:0]   lowv_reg, discv_reg, k_reg, kept_reg, maxsize_reg;
    logic [NW-1:0]    v_reg, w_reg, u_reg, ca_reg, x_reg, d_reg, aroot_reg, comp_reg;
    logic [ECW-1:0]   pos_reg, ei_reg;
    logic [EW-1:0]    sid_reg;
    logic             sv_reg, first_reg, found_reg;
    logic [KW-1:0]    best_reg, prev_reg;
    logic [ANS_W-1:0] maxw_reg, total_reg;
    logic [QCNT_W-1:0] qk_reg;

    // Shared unit
    logic [ANS_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_lt, alu_eq;

    scss_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .lt  (alu_lt),
        .eq  (alu_eq),
        .sum (alu_sum)
    );

    // Derived control
    logic [31:0]    from_w, to_w;
    logic           load_ok;
    logic [NCW-1:0] cp_m1, cp_m2, sp_m1;
    logic           scan_hit, cnd_ok, sel_ok, is_last;
    logic [KW-1:0]  cur_key;

    assign from_w  = 32'(from_node);
    assign to_w    = 32'(to_node);
    assign load_ok = cmd.load && (edges_reg < EDGE_CAP)
                   && (from_w != 32'd0) && (from_w <= 32'(MAX_NODES))
                   && (to_w != 32'd0) && (to_w <= 32'(MAX_NODES));
    assign esrc_wd = NW'(from_w - 32'd1);
    assign edst_wd = NW'(to_w - 32'd1);

    assign cp_m1 = cp_reg - NCW'(1);
    assign cp_m2 = cp_reg - NCW'(2);
    assign sp_m1 = sp_reg - NCW'(1);

    assign scan_hit = (esrc_rd == v_reg) && (NCW'(edst_rd) < nc);
    assign cnd_ok   = (NCW'(esrc_rd) < nc) && (NCW'(edst_rd) < nc) && (esrc_rd != edst_rd);
    assign cur_key  = {elen_rd, sid_reg};
    assign sel_ok   = sv_reg && ecand_rd && (first_reg || (cur_key > prev_reg))
                    && (!found_reg || (cur_key < best_reg));
    assign is_last  = ((qk_reg + QCNT_W'(1)) == q);

    assign busy = (state_reg != S_IDLE);

    // Edge table ports
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            esrc_mem[edge_wa] <= esrc_wd;
            edst_mem[edge_wa] <= edst_wd;
            elen_mem[edge_wa] <= cost;
        end
        esrc_rd <= esrc_mem[edge_ra];
        edst_rd <= edst_mem[edge_ra];
        elen_rd <= elen_mem[elen_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ecand_we)
            ecand_mem[ei_reg[EW-1:0]] <= ecand_wd;
        if (ecomp_we)
            ecomp_mem[ei_reg[EW-1:0]] <= ca_reg;
        ecand_rd <= ecand_mem[elen_ra];
        ecomp_rd <= ecomp_mem[ecomp_ra];
    end

    // Node store ports
    always_ff @(posedge clk)
    begin
        if (disc_we)
            disc_mem[disc_wa] <= disc_wd;
        disc_rd <= disc_mem[disc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (low_we)
            low_mem[low_wa] <= low_wd;
        low_rd <= low_mem[low_ra];
    end

    always_ff @(posedge clk)
    begin
        if (onstk_we)
            onstk_mem[onstk_wa] <= onstk_wd;
        onstk_rd <= onstk_mem[onstk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ns_we)
            ns_mem[ns_wa] <= ns_wd;
        ns_rd <= ns_mem[ns_ra];
    end

    always_ff @(posedge clk)
    begin
        if (wn_we)
            wn_mem[wn_wa] <= wn_wd;
        wn_rd <= wn_mem[wn_ra];
    end

    always_ff @(posedge clk)
    begin
        if (wp_we)
            wp_mem[wp_wa] <= wp_wd;
        wp_rd <= wp_mem[wp_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cof_we)
            cof_mem[cof_wa] <= cof_wd;
        cofa_rd <= cof_mem[cofa_ra];
        cofb_rd <= cof_mem[cofb_ra];
    end

    always_ff @(posedge clk)
    begin
        if (csize_we)
            csize_mem[csize_wa] <= csize_wd;
        csize_rd <= csize_mem[csize_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cw_we)
            cw_mem[cw_wa] <= cw_wd;
        cw_rd <= cw_mem[cw_ra];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_wa] <= par_wd;
        par_rd <= par_mem[par_ra];
    end

    // Steer memory ports, shared unit and next state
    always_comb
    begin
        state_next = state_reg;
        edge_we  = 1'b0; edge_wa = edges_reg[EW-1:0]; edge_ra = '0; elen_ra = '0;
        ecand_we = 1'b0; ecand_wd = 1'b0; ecomp_we = 1'b0; ecomp_ra = '0;
        disc_we  = 1'b0; disc_wa = '0; disc_wd = '0; disc_ra = '0;
        low_we   = 1'b0; low_wa = '0; low_wd = '0; low_ra = '0;
        onstk_we = 1'b0; onstk_wa = '0; onstk_wd = 1'b0; onstk_ra = '0;
        ns_we    = 1'b0; ns_wa = '0; ns_wd = '0; ns_ra = '0;
        wn_we    = 1'b0; wn_wa = '0; wn_wd = '0; wn_ra = '0;
        wp_we    = 1'b0; wp_wa = '0; wp_wd = '0; wp_ra = '0;
        cof_we   = 1'b0; cof_wa = '0; cof_wd = '0; cofa_ra = '0; cofb_ra = '0;
        csize_we = 1'b0; csize_wa = '0; csize_wd = '0; csize_ra = '0;
        cw_we    = 1'b0; cw_wa = '0; cw_wd = '0; cw_ra = '0;
        par_we   = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;
        alu_a    = '0; alu_b = '0;
        res.valid  = 1'b0;
        res.index  = qk_reg[IDX_W-1:0];
        res.last   = is_last;
        res.answer = '0;

        case (qk_reg[IDX_W-1:0])
            ANS_COUNT:      res.answer = ANS_W'(kept_reg);
            ANS_MAX_SIZE:   res.answer = ANS_W'(maxsize_reg);
            ANS_MAX_WEIGHT: res.answer = maxw_reg;
            ANS_TOTAL:      res.answer = total_reg;
            default:        res.answer = '0;
        endcase

        case (state_reg)
            S_IDLE:
            begin
                edge_we = load_ok;
                if (cmd.analyze)
                    state_next = S_CLR;
            end
            S_CLR:
            begin
                disc_we = 1'b1; disc_wa = clr_reg; disc_wd = UNSEEN;
                onstk_we = 1'b1; onstk_wa = clr_reg; onstk_wd = 1'b0;
                cw_we = 1'b1; cw_wa = clr_reg; cw_wd = '0;
                par_we = 1'b1; par_wa = clr_reg; par_wd = clr_reg;
                if (clr_reg == LAST_NODE)
                    state_next = S_ROOT;
            end
            S_ROOT:
            begin
                disc_ra = r_reg[NW-1:0];
                state_next = (r_reg == nc) ? S_CND : S_ROOT_W;
            end
            S_ROOT_W:
            begin
                state_next = (disc_rd == UNSEEN) ? S_VISIT : S_ROOT;
            end
            S_VISIT:
            begin
                disc_we = 1'b1; disc_wa = w_reg; disc_wd = vc_reg;
                low_we = 1'b1; low_wa = w_reg; low_wd = vc_reg;
                onstk_we = 1'b1; onstk_wa = w_reg; onstk_wd = 1'b1;
                ns_we = 1'b1; ns_wa = sp_reg[NW-1:0]; ns_wd = w_reg;
                wn_we = 1'b1; wn_wa = cp_reg[NW-1:0]; wn_wd = w_reg;
                wp_we = 1'b1; wp_wa = cp_reg[NW-1:0]; wp_wd = '0;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                wn_ra = cp_m1[NW-1:0];
                wp_ra = cp_m1[NW-1:0];
                state_next = (cp_reg == '0) ? S_ROOT : S_TOP_W;
            end
            S_TOP_W:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                edge_ra = pos_reg[EW-1:0];
                state_next = (pos_reg == edges_reg) ? S_POP : S_SCAN_W;
            end
            S_SCAN_W:
            begin
                wp_we = 1'b1; wp_wa = cp_m1[NW-1:0]; wp_wd = pos_reg + ECW'(1);
                disc_ra = edst_rd; onstk_ra = edst_rd; low_ra = v_reg;
                state_next = scan_hit ? S_EDGE_W : S_SCAN;
            end
            S_EDGE_W:
            begin
                alu_a = ANS_W'(disc_rd); alu_b = ANS_W'(low_rd);
                if (disc_rd == UNSEEN)
                    state_next = S_VISIT;
                else
                begin
                    low_we = onstk_rd && alu_lt; low_wa = v_reg; low_wd = disc_rd;
                    state_next = S_SCAN;
                end
            end
            S_POP:
            begin
                wn_ra = cp_m2[NW-1:0]; low_ra = v_reg;
                state_next = S_POP_W1;
            end
            S_POP_W1:
            begin
                low_ra = wn_rd; disc_ra = v_reg;
                state_next = S_POP_W2;
            end
            S_POP_W2:
            begin
                alu_a = ANS_W'(lowv_reg); alu_b = ANS_W'(low_rd);
                low_we = (cp_reg != '0) && alu_lt; low_wa = u_reg; low_wd = lowv_reg;
                state_next = S_POP_W3;
            end
            S_POP_W3:
            begin
                alu_a = ANS_W'(lowv_reg); alu_b = ANS_W'(discv_reg);
                state_next = alu_eq ? S_POPC : S_TOP;
            end
            S_POPC:
            begin
                ns_ra = sp_m1[NW-1:0];
                state_next = S_POPC_W;
            end
            S_POPC_W:
            begin
                onstk_we = 1'b1; onstk_wa = ns_rd; onstk_wd = 1'b0;
                cof_we = 1'b1; cof_wa = ns_rd; cof_wd = ncomp_reg[NW-1:0];
                if ((ns_rd != v_reg) && (sp_reg != '0))
                    state_next = S_POPC;
                else
                begin
                    csize_we = 1'b1; csize_wa = ncomp_reg[NW-1:0];
                    csize_wd = size_reg + NCW'(1);
                    state_next = S_TOP;
                end
            end
            S_CND:
            begin
                edge_ra = ei_reg[EW-1:0];
                state_next = (ei_reg == edges_reg) ? S_SEL : S_CND_W1;
            end
            S_CND_W1:
            begin
                cofa_ra = esrc_rd; cofb_ra = edst_rd;
                ecand_we = !cnd_ok;
                state_next = cnd_ok ? S_CND_W2 : S_CND;
            end
            S_CND_W2:
            begin
                csize_ra = cofa_rd;
                ecand_we = (cofa_rd != cofb_rd);
                state_next = (cofa_rd == cofb_rd) ? S_CND_W3 : S_CND;
            end
            S_CND_W3:
            begin
                ecand_we = 1'b1; ecand_wd = (csize_rd >= NCW'(2));
                ecomp_we = 1'b1;
                state_next = S_CND;
            end
            S_SEL:
            begin
                elen_ra = ei_reg[EW-1:0];
                if (!sv_reg && (ei_reg == edges_reg))
                    state_next = S_SEL_E;
            end
            S_SEL_E:
            begin
                edge_ra = best_reg[EW-1:0]; ecomp_ra = best_reg[EW-1:0];
                state_next = found_reg ? S_FA0 : S_ANS;
            end
            S_FA0:
            begin
                state_next = S_FA;
            end
            S_FA:
            begin
                par_ra = x_reg;
                state_next = S_FA_W;
            end
            S_FA_W:
            begin
                state_next = (par_rd == x_reg) ? S_FB : S_FA;
            end
            S_FB:
            begin
                par_ra = x_reg;
                state_next = S_FB_W;
            end
            S_FB_W:
            begin
                cw_ra = comp_reg;
                if (par_rd != x_reg)
                    state_next = S_FB;
                else if (x_reg != aroot_reg)
                begin
                    par_we = 1'b1; par_wa = aroot_reg; par_wd = x_reg;
                    state_next = S_ADDW;
                end
                else
                    state_next = S_SEL;
            end
            S_ADDW:
            begin
                alu_a = cw_rd; alu_b = ANS_W'(prev_reg[KW-1:EW]);
                cw_we = 1'b1; cw_wa = comp_reg; cw_wd = alu_sum;
                state_next = S_SEL;
            end
            S_ANS:
            begin
                csize_ra = k_reg[NW-1:0]; cw_ra = k_reg[NW-1:0];
                state_next = (k_reg == ncomp_reg) ? S_EMIT : S_ANS_W;
            end
            S_ANS_W:
            begin
                alu_a = total_reg; alu_b = cw_rd;
                state_next = S_ANS;
            end
            S_EMIT:
            begin
                res.valid = 1'b1;
                if (res_take && is_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            edges_reg   <= '0;
            clr_reg     <= '0;
            r_reg       <= '0;
            vc_reg      <= '0;
            sp_reg      <= '0;
            cp_reg      <= '0;
            ncomp_reg   <= '0;
            size_reg    <= '0;
            lowv_reg    <= '0;
            discv_reg   <= '0;
            k_reg       <= '0;
            kept_reg    <= '0;
            maxsize_reg <= '0;
            v_reg       <= '0;
            w_reg       <= '0;
            u_reg       <= '0;
            ca_reg      <= '0;
            x_reg       <= '0;
            d_reg       <= '0;
            aroot_reg   <= '0;
            comp_reg    <= '0;
            pos_reg     <= '0;
            ei_reg      <= '0;
            sid_reg     <= '0;
            sv_reg      <= 1'b0;
            first_reg   <= 1'b0;
            found_reg   <= 1'b0;
            best_reg    <= '0;
            prev_reg    <= '0;
            maxw_reg    <= '0;
            total_reg   <= '0;
            qk_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (load_ok)
                        edges_reg <= edges_reg + ECW'(1);
                    clr_reg <= '0;
                end
                S_CLR:
                begin
                    clr_reg   <= clr_reg + NW'(1);
                    r_reg     <= '0;
                    vc_reg    <= '0;
                    sp_reg    <= '0;
                    cp_reg    <= '0;
                    ncomp_reg <= '0;
                end
                S_ROOT:
                begin
                    ei_reg <= '0;
                end
                S_ROOT_W:
                begin
                    if (disc_rd == UNSEEN)
                        w_reg <= r_reg[NW-1:0];
                    else
                        r_reg <= r_reg + NCW'(1);
                end
                S_VISIT:
                begin
                    vc_reg <= vc_reg + NCW'(1);
                    sp_reg <= sp_reg + NCW'(1);
                    cp_reg <= cp_reg + NCW'(1);
                end
                S_TOP:
                begin
                    if (cp_reg == '0)
                        r_reg <= r_reg + NCW'(1);
                end
                S_TOP_W:
                begin
                    v_reg   <= wn_rd;
                    pos_reg <= wp_rd;
                end
                S_SCAN_W:
                begin
                    pos_reg <= pos_reg + ECW'(1);
                    w_reg   <= edst_rd;
                end
                S_POP:
                begin
                    cp_reg <= cp_m1;
                end
                S_POP_W1:
                begin
                    lowv_reg <= low_rd;
                    u_reg    <= wn_rd;
                end
                S_POP_W2:
                begin
                    discv_reg <= disc_rd;
                end
                S_POP_W3:
                begin
                    size_reg <= '0;
                end
                S_POPC:
                begin
                    sp_reg <= sp_m1;
                end
                S_POPC_W:
                begin
                    if ((ns_rd != v_reg) && (sp_reg != '0))
                        size_reg <= size_reg + NCW'(1);
                    else
                        ncomp_reg <= ncomp_reg + NCW'(1);
                end
                S_CND:
                begin
                    if (ei_reg == edges_reg)
                    begin
                        ei_reg    <= '0;
                        sv_reg    <= 1'b0;
                        found_reg <= 1'b0;
                        first_reg <= 1'b1;
                    end
                end
                S_CND_W1:
                begin
                    if (!cnd_ok)
                        ei_reg <= ei_reg + ECW'(1);
                end
                S_CND_W2:
                begin
                    ca_reg <= cofa_rd;
                    if (cofa_rd != cofb_rd)
                        ei_reg <= ei_reg + ECW'(1);
                end
                S_CND_W3:
                begin
                    ei_reg <= ei_reg + ECW'(1);
                end
                S_SEL:
                begin
                    if (sel_ok)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= cur_key;
                    end
                    if (ei_reg != edges_reg)
                    begin
                        ei_reg  <= ei_reg + ECW'(1);
                        sid_reg <= ei_reg[EW-1:0];
                        sv_reg  <= 1'b1;
                    end
                    else
                        sv_reg <= 1'b0;
                end
                S_SEL_E:
                begin
                    if (found_reg)
                    begin
                        prev_reg  <= best_reg;
                        first_reg <= 1'b0;
                    end
                    k_reg       <= '0;
                    kept_reg    <= '0;
                    maxsize_reg <= '0;
                    maxw_reg    <= '0;
                    total_reg   <= '0;
                end
                S_FA0:
                begin
                    x_reg    <= esrc_rd;
                    d_reg    <= edst_rd;
                    comp_reg <= ecomp_rd;
                end
                S_FA_W:
                begin
                    if (par_rd == x_reg)
                    begin
                        aroot_reg <= x_reg;
                        x_reg     <= d_reg;
                    end
                    else
                        x_reg <= par_rd;
                end
                S_FB_W:
                begin
                    if (par_rd != x_reg)
                        x_reg <= par_rd;
                    else
                    begin
                        ei_reg    <= '0;
                        sv_reg    <= 1'b0;
                        found_reg <= 1'b0;
                    end
                end
                S_ANS_W:
                begin
                    if (csize_rd >= NCW'(2))
                    begin
                        kept_reg <= kept_reg + NCW'(1);
                        if (csize_rd > maxsize_reg)
                            maxsize_reg <= csize_rd;
                        if (cw_rd > maxw_reg)
                            maxw_reg <= cw_rd;
                        total_reg <= alu_sum;
                    end
                    k_reg <= k_reg + NCW'(1);
                end
                S_ANS:
                begin
                    qk_reg <= '0;
                end
                S_EMIT:
                begin
                    if (res_take)
                    begin
                        qk_reg <= qk_reg + QCNT_W'(1);
                        if (is_last)
                            edges_reg <= '0;
                    end
                end
                default:
                begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

endmodule

[rtl/core/strong_component_spanning_stats_unit.sv]
// ============================================================================
// strong_component_spanning_stats_unit
// Loads directed weighted edges and, on an analyze item, reports statistics of
// the minimum spanning weights of the strongly connected components.
// ============================================================================
// Edge loads: one transfer per cycle while idle. Analyze: clearing the node stores, the
// component search, candidate marking over the edges, a selection pass over the edge
// table per candidate edge (plus joining two trees and the union-find steps), answer
// collection per component, then one answer per cycle at best.
// Input is stalled until the last answer is taken by the output register.
// Reset (asynchronous, active low) empties the edge table, node_count 1, question_count 4.
module strong_component_spanning_stats_unit
    import scss_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [NODE_FW-1:0] from_node,
    input  logic [NODE_FW-1:0] to_node,
    input  logic [LEN_W-1:0]   cost,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ANS_W-1:0]   answer,
    output logic [IDX_W-1:0]   answer_index,
    output logic               last,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int NCW = $clog2(MAX_NODES) + 1;

    logic [CFG_W-1:0]  node_count_reg;
    logic [QCNT_W-1:0] question_count_reg;
    logic [NCW-1:0]    nc;
    logic [QCNT_W-1:0] q_eff;
    scss_cmd_t         cmd;
    scss_res_t         res;
    logic              busy, res_take;
    logic              out_valid_reg, last_reg;
    logic [ANS_W-1:0]  answer_reg;
    logic [IDX_W-1:0]  index_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg     <= CFG_W'(1);
            question_count_reg <= QCNT_W'(4);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NODE_COUNT)
                node_count_reg <= cfg_data;
            else
                question_count_reg <= cfg_data[QCNT_W-1:0];
        end
    end

    // Clamp configuration to the working range
    always_comb
    begin
        if (node_count_reg == '0)
            nc = NCW'(1);
        else if (32'(node_count_reg) > 32'(MAX_NODES))
            nc = NCW'(MAX_NODES);
        else
            nc = NCW'(node_count_reg);

        if (question_count_reg == '0)
            q_eff = QCNT_W'(1);
        else if (question_count_reg > QCNT_W'(4))
            q_eff = QCNT_W'(4);
        else
            q_eff = question_count_reg;
    end

    // Decode the input transfer
    assign in_stall    = busy;
    assign cmd.load    = in_valid && !busy && (mode == MODE_LOAD);
    assign cmd.analyze = in_valid && !busy && (mode == MODE_ANALYZE);

    scss_seq #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .from_node (from_node),
        .to_node   (to_node),
        .cost      (cost),
        .nc        (nc),
        .q         (q_eff),
        .res_take  (res_take),
        .res       (res),
        .busy      (busy)
    );

    // Output register: take a new answer whenever the slot is free or draining
    assign res_take = res.valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            answer_reg <= res.answer;
            index_reg  <= res.index;
            last_reg   <= res.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign answer       = answer_reg;
    assign answer_index = index_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    // Answers are only offered while the input side is held off
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> in_stall)
        else $error("answer offered while input accepted");

    // The flagged answer is the last one asked for
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> ((answer_index + IDX_W'(1)) == q_eff[IDX_W-1:0]))
        else $error("last flag on wrong answer");

    // An analyze transfer starts the sequencer
    a_analyze_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (mode == MODE_ANALYZE)) |=> in_stall)
        else $error("analyze transfer did not start the sequencer");
`endif

endmodule

[bench/tb_strong_component_spanning_stats_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_strong_component_spanning_stats_unit
// Loads small directed graphs edge by edge, triggers analysis and checks every
// answer against a local predictor of components and spanning weights.
// ----------------------------------------------------------------------------
module tb_strong_component_spanning_stats_unit;
    import scss_pkg::*;

    localparam int NODES = 256;
    localparam int EDGES = 1024;

    typedef struct {
        logic               mode;
        logic [NODE_FW-1:0] src;
        logic [NODE_FW-1:0] dst;
        logic [LEN_W-1:0]   len;
    } edge_item_t;

    typedef struct {
        logic [ANS_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic             last;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [NODE_FW-1:0] from_node;
    logic [NODE_FW-1:0] to_node;
    logic [LEN_W-1:0]   cost;
    logic               out_valid;
    logic               out_stall;
    logic [ANS_W-1:0]   answer;
    logic [IDX_W-1:0]   answer_index;
    logic               last;
    logic               cfg_we;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    strong_component_spanning_stats_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .from_node(from_node), .to_node(to_node), .cost(cost),
        .out_valid(out_valid), .out_stall(out_stall),
        .answer(answer), .answer_index(answer_index), .last(last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [7:0]     tbl_src [EDGES];
    logic [7:0]     tbl_dst [EDGES];
    logic [15:0]    tbl_len [EDGES];
    int             tbl_fill;
    logic [8:0]     nodes_reg;
    logic [2:0]     questions_reg;
    int             adj [NODES][$];
    bit             reach [NODES][NODES];
    int             rep [NODES];
    int             comp_size [NODES];
    int unsigned    comp_weight [NODES];
    int             uf_parent [NODES];

    edge_item_t     items_q [$];
    answer_t        answers_q [$];
    int             iss_cnt, acc_cnt;
    int             idle_pct, stall_pct;
    int             errors, answers_seen, analyses;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int uf_root(input int a);
        int r;
        r = a;
        while (uf_parent[r] != r) r = uf_parent[r];
        return r;
    endfunction

    // compute the answers for the stored edge table
    function automatic void predict_stats();
        int nc, q, s, d, v, u, w, k, kept, maxsize, a, b, e;
        int bfs [$];
        int cand [$];
        int unsigned maxw, total, sum;
        logic [ANS_W-1:0] stats [4];
        answer_t res;
        nc = (nodes_reg == 0) ? 1 : (nodes_reg > NODES ? NODES : nodes_reg);
        q = (questions_reg == 0) ? 1 : (questions_reg > 4 ? 4 : questions_reg);
        for (v = 0; v < NODES; v++)
        begin
            adj[v].delete();
            comp_size[v] = 0;
            comp_weight[v] = 0;
            uf_parent[v] = v;
        end
        for (e = 0; e < tbl_fill; e++)
            if (tbl_src[e] < nc && tbl_dst[e] < nc)
                adj[tbl_src[e]].insert(adj[tbl_src[e]].size(), int'(tbl_dst[e]));
        // reachability from each node
        for (v = 0; v < nc; v++)
        begin
            for (u = 0; u < nc; u++) reach[v][u] = 0;
            reach[v][v] = 1;
            bfs.delete();
            bfs.insert(bfs.size(), v);
            while (bfs.size() > 0)
            begin
                u = bfs.pop_front();
                for (k = 0; k < adj[u].size(); k++)
                begin
                    w = adj[u][k];
                    if (!reach[v][w])
                    begin
                        reach[v][w] = 1;
                        bfs.insert(bfs.size(), w);
                    end
                end
            end
        end
        // component representative: lowest mutually reachable node
        for (v = 0; v < nc; v++)
        begin
            rep[v] = v;
            for (u = 0; u < v; u++)
                if (reach[v][u] && reach[u][v])
                begin
                    rep[v] = u;
                    break;
                end
            comp_size[rep[v]]++;
        end
        // candidate internal edges, sorted by length
        for (e = 0; e < tbl_fill; e++)
        begin
            s = tbl_src[e];
            d = tbl_dst[e];
            if (s < nc && d < nc && s != d && rep[s] == rep[d] && comp_size[rep[s]] >= 2)
            begin
                k = cand.size();
                cand.insert(cand.size(), e);
                while (k > 0 && tbl_len[cand[k-1]] > tbl_len[e])
                begin
                    cand[k] = cand[k-1];
                    k--;
                end
                cand[k] = e;
            end
        end
        for (k = 0; k < cand.size(); k++)
        begin
            e = cand[k];
            a = uf_root(tbl_src[e]);
            b = uf_root(tbl_dst[e]);
            if (a != b)
            begin
                uf_parent[a] = b;
                sum = comp_weight[rep[tbl_src[e]]] + tbl_len[e];
                comp_weight[rep[tbl_src[e]]] = (sum > WMAX) ? WMAX : sum;
            end
        end
        kept = 0; maxsize = 0; maxw = 0; total = 0;
        for (v = 0; v < nc; v++)
            if (rep[v] == v && comp_size[v] >= 2)
            begin
                kept++;
                if (comp_size[v] > maxsize) maxsize = comp_size[v];
                if (comp_weight[v] > maxw) maxw = comp_weight[v];
                total += comp_weight[v];
                if (total > WMAX) total = WMAX;
            end
        stats[ANS_COUNT] = ANS_W'(kept);
        stats[ANS_MAX_SIZE] = ANS_W'(maxsize);
        stats[ANS_MAX_WEIGHT] = ANS_W'(maxw);
        stats[ANS_TOTAL] = ANS_W'(total);
        for (k = 0; k < q; k++)
        begin
            res.value = stats[k];
            res.index = IDX_W'(k);
            res.last = (k + 1 == q);
            answers_q.insert(answers_q.size(), res);
        end
        tbl_fill = 0;
        analyses++;
    endfunction

    // predict on each accepted input transfer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            acc_cnt <= acc_cnt + 1;
            if (mode == MODE_ANALYZE)
                predict_stats();
            else if (tbl_fill < EDGES && from_node >= 1 && from_node <= NODES
                     && to_node >= 1 && to_node <= NODES)
            begin
                tbl_src[tbl_fill] = 8'(from_node - 1);
                tbl_dst[tbl_fill] = 8'(to_node - 1);
                tbl_len[tbl_fill] = cost;
                tbl_fill++;
            end
        end
    end

    // check each accepted answer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            answers_seen++;
            if (answers_q.size() == 0)
                report("unexpected answer", 32'(answer), 32'd0);
            else
            begin
                if (answer !== answers_q[0].value)
                    report("answer", 32'(answer), 32'(answers_q[0].value));
                if (answer_index !== answers_q[0].index)
                    report("answer_index", 32'(answer_index), 32'(answers_q[0].index));
                if (last !== answers_q[0].last)
                    report("last", 32'(last), 32'(answers_q[0].last));
                void'(answers_q.pop_front());
            end
        end
    end

    // drive the next transfer once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || acc_cnt == iss_cnt)
            begin
                if (items_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    mode <= items_q[0].mode;
                    from_node <= items_q[0].src;
                    to_node <= items_q[0].dst;
                    cost <= items_q[0].len;
                    void'(items_q.pop_front());
                    in_valid <= 1'b1;
                    iss_cnt <= iss_cnt + 1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic add_item(input logic m, input int s, input int d, input int c);
        edge_item_t it;
        it.mode = m;
        it.src = NODE_FW'(s);
        it.dst = NODE_FW'(d);
        it.len = LEN_W'(c);
        items_q.insert(items_q.size(), it);
    endtask

    task automatic push_analyze();
        add_item(MODE_ANALYZE, $urandom_range(511), $urandom_range(511), $urandom_range(65535));
    endtask

    // hold until every transfer is taken and every answer has arrived
    task automatic wait_idle();
        wait (items_q.size() == 0 && acc_cnt == iss_cnt && answers_q.size() == 0);
        repeat (30) @(posedge clk);
    endtask

    // write a register once nothing is in flight
    task automatic write_cfg(input logic idx, input int value);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_NODE_COUNT) nodes_reg = 9'(value);
        else questions_reg = 3'(value);
    endtask

    // random graph on nc nodes, mostly in range with some stray endpoints
    task automatic push_graph(input int nc, input int n_edges);
        int k, s, d;
        for (k = 0; k < n_edges; k++)
        begin
            s = $urandom_range(nc, 1);
            d = $urandom_range(nc, 1);
            if ($urandom_range(99) < 8) s = $urandom_range(511);
            if ($urandom_range(99) < 8) d = $urandom_range(511);
            add_item(MODE_LOAD, s, d, ($urandom_range(9) == 0) ? 16'hFFFF : $urandom_range(65535));
        end
        push_analyze();
    endtask

    initial
    begin
        int g, nc, k, pct_set;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        mode = MODE_LOAD;
        from_node = '0;
        to_node = '0;
        cost = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_NODE_COUNT;
        cfg_data = '0;
        iss_cnt = 0; acc_cnt = 0; idle_pct = 0; stall_pct = 0;
        errors = 0; answers_seen = 0; analyses = 0;
        tbl_fill = 0; nodes_reg = 1; questions_reg = 4;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // analysis with reset settings and no edges
        push_analyze();
        wait_idle();

        // triangle with extreme costs, self loop, parallel edge and dropped nodes
        write_cfg(CFG_NODE_COUNT, 3);
        add_item(MODE_LOAD, 1, 2, 0);
        add_item(MODE_LOAD, 2, 3, 16'hFFFF);
        add_item(MODE_LOAD, 3, 1, 5);
        add_item(MODE_LOAD, 2, 2, 1);
        add_item(MODE_LOAD, 1, 2, 1);
        add_item(MODE_LOAD, 0, 2, 7);
        add_item(MODE_LOAD, 2, 257, 7);
        add_item(MODE_LOAD, 511, 1, 7);
        add_item(MODE_LOAD, 256, 1, 7);
        add_item(MODE_LOAD, 3, 256, 7);
        push_analyze();
        wait_idle();

        // clamped settings and a table holding a single self loop
        write_cfg(CFG_NODE_COUNT, 0);
        write_cfg(CFG_QUESTION_COUNT, 0);
        add_item(MODE_LOAD, 1, 1, 9);
        push_analyze();
        wait_idle();
        write_cfg(CFG_QUESTION_COUNT, 7);
        write_cfg(CFG_NODE_COUNT, 2);
        add_item(MODE_LOAD, 1, 2, 300);
        add_item(MODE_LOAD, 2, 1, 200);
        push_analyze();
        push_analyze();
        wait_idle();

        // random graphs through the idling phases
        for (g = 0; g < 28; g++)
        begin
            pct_set = (g / 7) % 4;
            idle_pct = (pct_set == 1 || pct_set == 3) ? ((pct_set == 3) ? 14 : 45) : 0;
            stall_pct = (pct_set == 2 || pct_set == 3) ? ((pct_set == 3) ? 14 : 45) : 0;
            if (g % 3 == 0) write_cfg(CFG_QUESTION_COUNT, $urandom_range(7));
            nc = $urandom_range(12, 2);
            write_cfg(CFG_NODE_COUNT, nc);
            push_graph(nc, $urandom_range(2 * nc + 2, 1));
            if (g % 5 == 0) wait_idle();
        end
        wait_idle();

        // node count above the limit: a ring through twenty nodes, then a sparse graph
        idle_pct = 0;
        stall_pct = 14;
        write_cfg(CFG_QUESTION_COUNT, 4);
        write_cfg(CFG_NODE_COUNT, 511);
        for (k = 0; k < 20; k++)
            add_item(MODE_LOAD, k + 1, ((k + 1) % 20) + 1, 16'hFFFF);
        push_analyze();
        wait_idle();
        write_cfg(CFG_NODE_COUNT, 256);
        push_graph(256, 12);
        wait_idle();

        $display("covered %0d analyses and %0d answers over four idling phases,",
                 analyses, answers_seen);
        $display("including clamped settings, stray nodes and the largest node count");
        if (errors == 0)
            $display("tb_strong_component_spanning_stats_unit: PASS");
        else
            $display("tb_strong_component_spanning_stats_unit: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #60000000;
        $display("timeout at %0t", $realtime);
        $display("tb_strong_component_spanning_stats_unit: FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/core/scss_pkg.sv
rtl/core/scss_alu.sv
rtl/core/scss_seq.sv
rtl/core/strong_component_spanning_stats_unit.sv
bench/tb_strong_component_spanning_stats_unit.sv
